[rtl/tlq_pkg.sv]
// ----------------------------------------------------------------------------
// tlq_pkg
// Types, constants and ring index helpers for the terminal line input queue.
// ----------------------------------------------------------------------------
package tlq_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int IDX_MOD   = 2 * BUF_DEPTH;
    localparam int IDX_W     = $clog2(IDX_MOD);
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_ADDR_W = 4;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7f;

    typedef enum logic [1:0] {
        CFG_ECHO  = 2'd0,
        CFG_CANON = 2'd1,
        CFG_CRNL  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_ECHO  = 2'd0,
        OUT_BYTE  = 2'd1,
        OUT_EMPTY = 2'd2,
        OUT_EOF   = 2'd3
    } out_kind_t;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_POP   = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic echo;
        logic canon;
        logic crnl;
    } cfg_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       first;
    } cmd_t;

    typedef struct packed {
        out_kind_t  kind;
        logic [7:0] data;
        logic       line_end;
    } result_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    function automatic idx_t idx_inc(input idx_t a);
        idx_t r;
        if (a == IDX_W'(IDX_MOD - 1))
            r = '0;
        else
            r = a + idx_t'(1);
        return r;
    endfunction

    function automatic idx_t idx_dec(input idx_t a);
        idx_t r;
        if (a == '0)
            r = IDX_W'(IDX_MOD - 1);
        else
            r = a - idx_t'(1);
        return r;
    endfunction

    // a - b modulo the index range
    function automatic idx_t idx_diff(input idx_t a, input idx_t b);
        logic [IDX_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (t[IDX_W])
            t = t + (IDX_W+1)'(IDX_MOD);
        return t[IDX_W-1:0];
    endfunction

    function automatic addr_t idx_addr(input idx_t a);
        idx_t r;
        if (a >= IDX_W'(BUF_DEPTH))
            r = a - IDX_W'(BUF_DEPTH);
        else
            r = a;
        return r[ADDR_W-1:0];
    endfunction

endpackage

[rtl/tlq_req_if.sv]
// ----------------------------------------------------------------------------
// tlq_req_if
// Request channel: received byte or reader pop.
// ----------------------------------------------------------------------------
interface tlq_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    logic       read_first;

    modport source (output valid, output kind, output rx_byte, output read_first,
                    input ready);
    modport sink (input valid, input kind, input rx_byte, input read_first,
                  output ready);
endinterface

[rtl/tlq_rsp_if.sv]
// ----------------------------------------------------------------------------
// tlq_rsp_if
// Result channel: echo bytes and read results.
// ----------------------------------------------------------------------------
interface tlq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       line_end;
    logic       last;

    modport source (output valid, output out_kind, output out_byte, output line_end,
                    output last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input line_end,
                  input last, output ready);
endinterface

[rtl/tlq_cfg.sv]
// ----------------------------------------------------------------------------
// tlq_cfg
// APB register file for echo, canonical mode and CR translation.
// ----------------------------------------------------------------------------
module tlq_cfg
    import tlq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(paddr[3:2]))
                CFG_ECHO:  cfg_next.echo  = pwdata[0];
                CFG_CANON: cfg_next.canon = pwdata[0];
                CFG_CRNL:  cfg_next.crnl  = pwdata[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[3:2]))
            CFG_ECHO:  prdata = {31'd0, cfg_reg.echo};
            CFG_CANON: prdata = {31'd0, cfg_reg.canon};
            CFG_CRNL:  prdata = {31'd0, cfg_reg.crnl};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{echo: 1'b1, canon: 1'b1, crnl: 1'b1};
        else
            cfg_reg <= cfg_next;
    end

endmodule

[rtl/tlq_front.sv]
// ----------------------------------------------------------------------------
// tlq_front
// Accepts requests, drops swallowed bytes and turns the rest into commands.
// ----------------------------------------------------------------------------
module tlq_front
    import tlq_pkg::*;
(
    tlq_req_if.sink req,
    input  cfg_t    cfg,
    output logic    push_valid,
    output cmd_t    push_cmd,
    input  logic    push_ready
);

    logic [7:0] rx;
    logic       drop;

    assign rx        = req.rx_byte;
    assign req.ready = push_ready;

    always_comb
    begin
        drop           = 1'b0;
        push_cmd.op    = CMD_POP;
        push_cmd.data  = rx;
        push_cmd.first = req.read_first;
        if (!req.kind)
        begin
            push_cmd.op = CMD_STORE;
            if (cfg.canon && (rx inside {8'h02, 8'h08, 8'h0c, 8'h0e, 8'h0f,
                                         8'h10, 8'h13, 8'h14, 8'h15}))
                drop = 1'b1;
            else if (cfg.canon && rx == CH_DEL)
                push_cmd.op = CMD_ERASE;
            else if (rx == CH_NUL)
                drop = 1'b1;
            else if (cfg.crnl && rx == CH_CR)
                push_cmd.data = CH_LF;
        end
    end

    // swallowed bytes are taken without a queue entry
    assign push_valid = req.valid && !drop;

endmodule

[rtl/tlq_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tlq_cmd_fifo
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module tlq_cmd_fifo
    import tlq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CMDQ_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CMDQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/tlq_back.sv]
// ----------------------------------------------------------------------------
// tlq_back
// Executes commands on the ring buffer and sends out the results.
// ----------------------------------------------------------------------------
module tlq_back
    import tlq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     cmd_valid,
    input  cmd_t     cmd,
    output logic     cmd_ready,
    tlq_rsp_if.source rsp
);

    logic [7:0]  mem [BUF_DEPTH];
    logic [7:0]  rd_data_reg;
    logic        mem_we, mem_re;
    addr_t       mem_waddr, mem_raddr;

    back_state_t state_reg, state_next;
    idx_t        read_idx_reg, read_idx_next;
    idx_t        commit_idx_reg, commit_idx_next;
    idx_t        edit_idx_reg, edit_idx_next;
    logic        first_reg, first_next;
    result_t     pend_reg [3];
    result_t     pend_next [3];
    logic [1:0]  pend_cnt_reg, pend_cnt_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, out_res_next;
    logic        out_last_reg, out_last_next;
    logic        out_load;

    idx_t        edit_inc;
    idx_t        fill_now;
    idx_t        fill_after;

    assign edit_inc   = idx_inc(edit_idx_reg);
    assign fill_now   = idx_diff(edit_idx_reg, read_idx_reg);
    assign fill_after = idx_diff(edit_inc, read_idx_reg);

    assign cmd_ready = (state_reg == BK_IDLE);
    assign out_load  = (state_reg == BK_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        read_idx_next   = read_idx_reg;
        commit_idx_next = commit_idx_reg;
        edit_idx_next   = edit_idx_reg;
        first_next      = first_reg;
        pend_next       = pend_reg;
        pend_cnt_next   = pend_cnt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = idx_addr(edit_idx_reg);
        mem_raddr       = idx_addr(read_idx_reg);
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_STORE:
                        begin
                            if (fill_now < IDX_W'(BUF_DEPTH))
                            begin
                                mem_we        = 1'b1;
                                edit_idx_next = edit_inc;
                                if (!cfg.canon || cmd.data == CH_LF || cmd.data == CH_EOT ||
                                    fill_after == IDX_W'(BUF_DEPTH))
                                    commit_idx_next = edit_inc;
                                if (cfg.echo)
                                begin
                                    state_next = BK_EMIT;
                                    if (cmd.data == CH_LF)
                                    begin
                                        pend_next[0]  = '{OUT_ECHO, CH_CR, 1'b0};
                                        pend_next[1]  = '{OUT_ECHO, cmd.data, 1'b0};
                                        pend_cnt_next = 2'd2;
                                    end
                                    else
                                    begin
                                        pend_next[0]  = '{OUT_ECHO, cmd.data, 1'b0};
                                        pend_cnt_next = 2'd1;
                                    end
                                end
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (edit_idx_reg != commit_idx_reg)
                            begin
                                edit_idx_next = idx_dec(edit_idx_reg);
                                if (cfg.echo)
                                begin
                                    state_next    = BK_EMIT;
                                    pend_next[0]  = '{OUT_ECHO, CH_BS, 1'b0};
                                    pend_next[1]  = '{OUT_ECHO, CH_SP, 1'b0};
                                    pend_next[2]  = '{OUT_ECHO, CH_BS, 1'b0};
                                    pend_cnt_next = 2'd3;
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (read_idx_reg == commit_idx_reg)
                            begin
                                state_next    = BK_EMIT;
                                pend_next[0]  = '{OUT_EMPTY, 8'h00, 1'b0};
                                pend_cnt_next = 2'd1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                first_next = cmd.first;
                                state_next = BK_READ;
                            end
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                state_next    = BK_EMIT;
                pend_cnt_next = 2'd1;
                // end of file stays queued unless it opens the read call
                if (rd_data_reg == CH_EOT)
                begin
                    if (first_reg)
                        read_idx_next = idx_inc(read_idx_reg);
                    pend_next[0] = '{OUT_EOF, 8'h00, 1'b0};
                end
                else
                begin
                    read_idx_next = idx_inc(read_idx_reg);
                    pend_next[0]  = '{OUT_BYTE, rd_data_reg,
                                      cfg.canon && rd_data_reg == CH_LF};
                end
            end
            BK_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = pend_reg[0];
                    out_last_next  = (pend_cnt_reg == 2'd1);
                    pend_next[0]   = pend_reg[1];
                    pend_next[1]   = pend_reg[2];
                    pend_cnt_next  = pend_cnt_reg - 2'd1;
                    if (pend_cnt_reg == 2'd1)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            read_idx_reg   <= '0;
            commit_idx_reg <= '0;
            edit_idx_reg   <= '0;
            pend_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_idx_reg   <= read_idx_next;
            commit_idx_reg <= commit_idx_next;
            edit_idx_reg   <= edit_idx_next;
            pend_cnt_reg   <= pend_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= cmd.data;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_kind = out_res_reg.kind;
    assign rsp.out_byte = out_res_reg.data;
    assign rsp.line_end = out_res_reg.line_end;
    assign rsp.last     = out_last_reg;

endmodule

[rtl/tty_line_edit_input_queue_unit.sv]
// ----------------------------------------------------------------------------
// tty_line_edit_input_queue_unit
// Terminal input line discipline over a ring buffer with edit and commit.
// ----------------------------------------------------------------------------
//   channel  direction  transfer carries
//   req      in         kind, rx_byte, read_first
//   rsp      out        out_kind, out_byte, line_end, last
//   apb      in/out     echo_enable, line_mode, cr_to_nl at 0x0, 0x4, 0x8
//
// a command is taken while the executor is idle; a pop first does a registered
// ring read; the next command waits until its last result, if any, is loaded out
// swallowed bytes leave the front with no queue entry
// the two-entry command queue lets requests arrive while results are stalled
// reset clears the indices; the ring contents are left as they are
// ----------------------------------------------------------------------------
module tty_line_edit_input_queue_unit
    import tlq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tlq_req_if.sink               req,
    tlq_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;
    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    tlq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlq_front u_front (
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    tlq_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd),
        .pop_ready  (cmd_ready)
    );

    tlq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule
